[sv/ffdv_pkg.sv]
`default_nettype none

package ffdv_pkg;

  localparam int DefQueueDepth = 16;
  localparam int DataW         = 32;
  localparam int CmdW          = 2;
  localparam int StatW         = 2;
  localparam int OccW          = 5;

  localparam logic [CmdW-1:0] CmdEnqueue = 2'd0;
  localparam logic [CmdW-1:0] CmdDequeue = 2'd1;
  localparam logic [CmdW-1:0] CmdDelete  = 2'd2;

  localparam logic [StatW-1:0] StatDone     = 2'd0;
  localparam logic [StatW-1:0] StatFull     = 2'd1;
  localparam logic [StatW-1:0] StatEmpty    = 2'd2;
  localparam logic [StatW-1:0] StatNotFound = 2'd3;

  // Broadcast to every cell of the chain in the execute cycle.
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic             del;
    logic [DataW-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/ffdv_cell.sv]
`default_nettype none

module ffdv_cell
  import ffdv_pkg::*;
(
  input  wire              clk_i,
  input  wire cell_ctrl_t  ctrl_i,
  input  wire              occupied_i,
  input  wire              tail_i,
  input  wire              found_i,
  input  wire [DataW-1:0]  nbr_value_i,
  output logic [DataW-1:0] value_o,
  output logic             found_o
);

  logic [DataW-1:0] value_q, value_d;
  logic             match;
  logic             shift;

  assign match   = ctrl_i.del & occupied_i & (value_q == ctrl_i.key);
  assign found_o = found_i | match;

  // On dequeue, or at/behind a deleted entry, a cell copies its right neighbor.
  assign shift = ctrl_i.deq | (ctrl_i.del & found_o);

  always_comb begin
    value_d = value_q;
    if (shift) begin
      value_d = nbr_value_i;
    end else if (ctrl_i.enq && tail_i) begin
      value_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[sv/fifo_with_delete_by_value.sv]
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  command_i, data_value_i
// out      output     out_valid_o / out_stall_i status_o, result_value_o, occupancy_o
//
// For each command the transaction is registered, then the cell
// chain compares, shifts or loads in the execute cycle and the result register loads.
// A new command is accepted in the cycle after the execute cycle; the input is
// stalled while a command waits in execute.
// Reset clears the entry count and the control state; cell contents are not reset.
// A stalled result holds the execute cycle of the next command until it is taken.

module fifo_with_delete_by_value
  import ffdv_pkg::*;
#(
  parameter int QueueDepth = DefQueueDepth
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  [CmdW-1:0]         command_i,
  input  wire signed [DataW-1:0]  data_value_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic signed [DataW-1:0] result_value_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int CountW = $clog2(QueueDepth + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(QueueDepth);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic              state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CmdW-1:0]   cmd_q;
  logic [DataW-1:0]  key_q;
  logic              out_valid_q;
  logic [StatW-1:0]  status_q, status_d;
  logic [DataW-1:0]  result_q, result_d;

  logic              in_accept;
  logic              exec_fire;
  logic              full;
  logic              empty;
  cell_ctrl_t        ctrl;

  logic [DataW-1:0]  value_w [QueueDepth];
  logic [QueueDepth:0] found_w;
  logic [QueueDepth-1:0] occupied_w;
  logic [QueueDepth-1:0] tail_w;
  logic [CountW+OccW-1:0] occ_wide;

  assign in_stall_o = (state_q == StExec);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign exec_fire  = (state_q == StExec) & (~out_valid_q | ~out_stall_i);

  assign full  = (count_q == CountMax);
  assign empty = (count_q == '0);

  assign ctrl.enq = exec_fire & (cmd_q == CmdEnqueue) & ~full;
  assign ctrl.deq = exec_fire & (cmd_q == CmdDequeue) & ~empty;
  assign ctrl.del = exec_fire & (cmd_q == CmdDelete);
  assign ctrl.key = key_q;

  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [DataW-1:0] nbr_value;

    assign occupied_w[i] = (count_q > CountW'(i));
    assign tail_w[i]     = (count_q == CountW'(i));

    if (i == QueueDepth - 1) begin : g_last
      assign nbr_value = value_w[i];
    end else begin : g_mid
      assign nbr_value = value_w[i+1];
    end

    ffdv_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied_w[i]),
      .tail_i      (tail_w[i]),
      .found_i     (found_w[i]),
      .nbr_value_i (nbr_value),
      .value_o     (value_w[i]),
      .found_o     (found_w[i+1])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = StatDone;
    result_d = '0;
    case (cmd_q)
      CmdEnqueue: begin
        if (full) begin
          status_d = StatFull;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CmdDequeue: begin
        if (empty) begin
          status_d = StatEmpty;
        end else begin
          result_d = value_w[0];
          count_d  = count_q - 1'b1;
        end
      end
      CmdDelete: begin
        if (found_w[QueueDepth]) begin
          count_d = count_q - 1'b1;
        end else begin
          status_d = StatNotFound;
        end
      end
      default: begin
        status_d = StatDone;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_fire) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= command_i;
      key_q <= $unsigned(data_value_i);
    end
    if (exec_fire) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  assign occ_wide       = {{OccW{1'b0}}, count_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = $signed(result_q);
  assign occupancy_o    = occ_wide[OccW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("entry count exceeds queue depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StExec))
    else $error("accepted transaction did not enter execute");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(exec_fire))
    else $error("result appeared without an execute cycle");

  a_count_at_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(exec_fire))
    else $error("entry count changed outside an execute cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StatFull) |-> full)
    else $error("full status reported while queue not full");

endmodule

`default_nettype wire
